// ===== src/pmu_pkg.sv =====
package pmu_pkg;

  localparam int MAX_DEGREE_DEF = 31;

  localparam int COEF_W  = 16;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int ACC_W   = 40;
  localparam int POWER_W = 6;
  localparam int M_DATA_W = 48;

  typedef enum logic [1:0] {
    ST_LOAD_A,
    ST_LOAD_B,
    ST_ISSUE,
    ST_WAIT
  } pmu_state_t;

endpackage

// ===== src/polynomial_multiply_unit.sv =====
// Loading: one coefficient is taken per cycle while the block loads A and then B.
// Product: coefficient k needs one multiply-accumulate per index pair in its diagonal,
// issued one per cycle to the shared multiplier; the memory read, multiply and
// accumulate stages then drain, and the output register must be free, before the
// next power starts.
// Reset (synchronous, rst high) clears the sequencer, counts, flags and output valid.
module polynomial_multiply_unit
  import pmu_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [COEF_W-1:0]   s_tdata,   // coefficient [15:0]
  input  logic                s_tlast,   // final_coef
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // product_coef [39:0], power [45:40], zero [47:46]
  output logic                m_tlast,   // final_result
  output logic                m_tuser    // too_long
);

  localparam int SLOTS = MAX_DEGREE + 1;
  localparam int CIDX  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int KW    = $clog2(2 * MAX_DEGREE + 1);
  localparam int CMP_W = ((KW > CNT_W) ? KW : CNT_W) + 1;

  pmu_state_t state, state_next;

  logic signed [COEF_W-1:0] first_mem  [SLOTS];
  logic signed [COEF_W-1:0] second_mem [SLOTS];

  logic [CNT_W-1:0] first_count, second_count;
  logic             overflow_seen;
  logic [KW-1:0]    k;
  logic [CIDX-1:0]  i, j;
  logic             term_first;

  logic accept, issue, term_last, load_out, final_k, room;

  // Pipeline: read data, product, accumulator.
  logic signed [COEF_W-1:0] a_rd, b_rd;
  logic                     v1, first1, last1;
  logic signed [PROD_W-1:0] prod;
  logic                     v2, first2, last2;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;

  logic [CMP_W-1:0] kn_w, nb_w, na_w, fk_w;
  logic [KW-1:0]    kn;

  assign accept    = s_tvalid && s_tready;
  assign term_last = ({{(CMP_W-CIDX){1'b0}}, i} == na_w - CMP_W'(1)) || (j == '0);
  assign room      = !m_tvalid || m_tready;

  assign na_w = CMP_W'(first_count);
  assign nb_w = CMP_W'(second_count);
  assign fk_w = na_w + nb_w - CMP_W'(2);
  assign final_k = (CMP_W'(k) == fk_w);
  assign kn   = k + KW'(1);
  assign kn_w = CMP_W'(kn);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD_A: if (accept && s_tlast) state_next = ST_LOAD_B;
      ST_LOAD_B: if (accept && s_tlast) state_next = ST_ISSUE;
      ST_ISSUE:  if (term_last) state_next = ST_WAIT;
      ST_WAIT: begin
        if (done && room) state_next = final_k ? ST_LOAD_A : ST_ISSUE;
      end
      default: state_next = ST_LOAD_A;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_LOAD_A) || (state == ST_LOAD_B);
    issue    = (state == ST_ISSUE);
    load_out = (state == ST_WAIT) && done && room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD_A;
    end else begin
      state <= state_next;
    end
  end

  // Coefficient stores.
  always_ff @(posedge clk) begin
    if (accept && (first_count < CNT_W'(SLOTS)) && (state == ST_LOAD_A)) begin
      first_mem[first_count[CIDX-1:0]] <= s_tdata;
    end
    if (accept && (second_count < CNT_W'(SLOTS)) && (state == ST_LOAD_B)) begin
      second_mem[second_count[CIDX-1:0]] <= s_tdata;
    end
    a_rd <= first_mem[i];
    b_rd <= second_mem[j];
  end

  // Counts, flag and the index sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      k             <= '0;
      i             <= '0;
      j             <= '0;
      term_first    <= 1'b0;
    end else begin
      if (accept) begin
        if (state == ST_LOAD_A) begin
          if (first_count < CNT_W'(SLOTS)) first_count <= first_count + CNT_W'(1);
          else overflow_seen <= 1'b1;
        end else begin
          if (second_count < CNT_W'(SLOTS)) second_count <= second_count + CNT_W'(1);
          else overflow_seen <= 1'b1;
        end
        if (state == ST_LOAD_B && s_tlast) begin
          k          <= '0;
          i          <= '0;
          j          <= '0;
          term_first <= 1'b1;
        end
      end
      if (issue) begin
        term_first <= 1'b0;
        if (!term_last) begin
          i <= i + CIDX'(1);
          j <= j - CIDX'(1);
        end
      end
      if (load_out) begin
        if (final_k) begin
          first_count   <= '0;
          second_count  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          // Next diagonal starts where the index into B is as high as it may be.
          k          <= kn;
          term_first <= 1'b1;
          if (kn_w < nb_w) begin
            i <= '0;
            j <= kn[CIDX-1:0];
          end else begin
            i <= CIDX'(kn_w - nb_w + CMP_W'(1));
            j <= CIDX'(nb_w - CMP_W'(1));
          end
        end
      end
    end
  end

  // Multiply and accumulate pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (v2 && last2) done <= 1'b1;
      else if (load_out) done <= 1'b0;
    end
    first1 <= term_first;
    last1  <= term_last;
    prod   <= a_rd * b_rd;
    first2 <= first1;
    last2  <= last1;
    if (v2) begin
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      m_tdata <= {{(M_DATA_W-ACC_W-POWER_W){1'b0}}, POWER_W'(k), acc};
      m_tlast <= final_k;
      m_tuser <= overflow_seen;
    end
  end

  a_out_valid : assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result not presented after output load");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (v2 && last2) |-> !done)
    else $error("finished sum overwritten before transfer");

  a_idle_load : assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!done && !v1 && !v2))
    else $error("loading while multiply pipeline busy");

  a_end_product : assert property (@(posedge clk) disable iff (rst)
    (load_out && final_k) |=> (state == ST_LOAD_A && first_count == '0))
    else $error("product end did not return to loading");

endmodule

// ===== tb/tb_polynomial_multiply_unit.sv =====
`timescale 1ns / 100ps

module tb_polynomial_multiply_unit;
  import pmu_pkg::*;

  localparam int COEF_SLOTS  = MAX_DEGREE_DEF + 1;
  localparam int PROD_SLOTS  = 2 * MAX_DEGREE_DEF + 1;
  localparam int PAD_W       = M_DATA_W - ACC_W - POWER_W;
  localparam int RANDOM_ITEMS = 135;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_GAP      = 18;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [POWER_W-1:0]      power;
    logic                    top_term;
    logic                    too_long;
  } product_term_t;

  // Tracks both operand stores and queues the product terms that the block owes.
  class poly_product_scoreboard;
    logic signed [COEF_W-1:0] a_coefs[COEF_SLOTS];
    logic signed [COEF_W-1:0] b_coefs[COEF_SLOTS];
    int unsigned a_count;
    int unsigned b_count;
    bit on_b;
    bit overflow;
    product_term_t owed_terms[$];
    int unsigned errors;

    function new();
      a_count  = 0;
      b_count  = 0;
      on_b     = 1'b0;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return owed_terms.size();
    endfunction

    function void note_coef(logic [COEF_W-1:0] coef, logic fin);
      longint sums[PROD_SLOTS];
      product_term_t term;
      int unsigned n;
      if (!on_b) begin
        if (a_count < COEF_SLOTS) begin
          a_coefs[a_count] = coef;
          a_count++;
        end else begin
          overflow = 1'b1;
        end
        if (fin) on_b = 1'b1;
        return;
      end
      if (b_count < COEF_SLOTS) begin
        b_coefs[b_count] = coef;
        b_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!fin) return;
      for (int k = 0; k < PROD_SLOTS; k++) sums[k] = 0;
      for (int i = 0; i < a_count; i++) begin
        for (int j = 0; j < b_count; j++) begin
          sums[i + j] += longint'(a_coefs[i]) * longint'(b_coefs[j]);
        end
      end
      n = a_count + b_count - 1;
      for (int k = 0; k < n; k++) begin
        term.value    = sums[k][ACC_W-1:0];
        term.power    = k[POWER_W-1:0];
        term.top_term = (k == n - 1);
        term.too_long = overflow;
        owed_terms.push_back(term);
      end
      a_count  = 0;
      b_count  = 0;
      on_b     = 1'b0;
      overflow = 1'b0;
    endfunction

    function void check_term(logic [M_DATA_W-1:0] data, logic fin, logic flag);
      product_term_t want;
      logic signed [ACC_W-1:0] got_value;
      logic [POWER_W-1:0] got_power;
      logic [PAD_W-1:0] got_pad;
      got_value = data[ACC_W-1:0];
      got_power = data[ACC_W +: POWER_W];
      got_pad   = data[M_DATA_W-1 -: PAD_W];
      if (owed_terms.size() == 0) begin
        $display("%0t: unexpected result, power %0d value %0d", $time, got_power, got_value);
        errors++;
        return;
      end
      want = owed_terms.pop_front();
      if (got_value !== want.value) begin
        $display("%0t: coefficient of power %0d expected %0d actual %0d",
                 $time, want.power, want.value, got_value);
        errors++;
      end
      if (got_power !== want.power) begin
        $display("%0t: power expected %0d actual %0d", $time, want.power, got_power);
        errors++;
      end
      if (got_pad !== '0) begin
        $display("%0t: padding bits expected 0 actual %b", $time, got_pad);
        errors++;
      end
      if (fin !== want.top_term) begin
        $display("%0t: tlast at power %0d expected %b actual %b",
                 $time, want.power, want.top_term, fin);
        errors++;
      end
      if (flag !== want.too_long) begin
        $display("%0t: too-long flag at power %0d expected %b actual %b",
                 $time, want.power, want.too_long, flag);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [COEF_W-1:0]   s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  poly_product_scoreboard sb = new();
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int unsigned coefs_sent = 0;
  int unsigned cycles = 0;

  polynomial_multiply_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [COEF_W-1:0] mag;
    mag = COEF_W'($urandom_range(1, 300));
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return mag;
      4: return -mag;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 6) return $urandom_range(1, 4);
    if (r <= 8) return $urandom_range(5, 12);
    return $urandom_range(13, COEF_SLOTS);
  endfunction

  task automatic send_coef(input logic [COEF_W-1:0] coef, input logic fin);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= coef;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.note_coef(coef, fin);
    coefs_sent++;
  endtask

  task automatic send_poly(input int unsigned len);
    for (int i = 0; i < len; i++) send_coef(pick_coef(), i == len - 1);
  endtask

  // Holds the input off until every owed product term has been taken.
  task automatic drain_products();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned start_count;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sign extremes, zero, and operands of one, two and three terms.
    send_coef(16'h8000, 1'b1);
    send_coef(16'h8000, 1'b1);
    send_coef(16'h7FFF, 1'b1);
    send_coef(16'h8000, 1'b1);
    send_coef(16'h8000, 1'b0);
    send_coef(16'h7FFF, 1'b0);
    send_coef(16'h0000, 1'b1);
    send_coef(16'h7FFF, 1'b0);
    send_coef(16'h0001, 1'b1);
    send_coef(16'h0000, 1'b1);
    send_coef(16'hFFFF, 1'b1);
    drain_products();

    start_count = coefs_sent;
    // A runs one past capacity so its final mark lands on a dropped coefficient,
    // and B is full, giving the longest product.
    tx_burst = 1'b0;
    send_poly(COEF_SLOTS + 1);
    send_poly(COEF_SLOTS);
    // Same again on the B side.
    tx_burst = 1'b1;
    send_poly(1);
    send_poly(COEF_SLOTS + 2);
    drain_products();

    while (coefs_sent - start_count < RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      send_poly(($urandom_range(0, 11) == 0) ? COEF_SLOTS + $urandom_range(1, 3) : pick_length());
      send_poly(($urandom_range(0, 11) == 0) ? COEF_SLOTS + $urandom_range(1, 3) : pick_length());
      if ($urandom_range(0, 4) == 0) drain_products();
    end

    drain_products();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_term(m_tdata, m_tlast, m_tuser);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles, %0d terms still owed",
             $time, CYCLE_LIMIT, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
